// ===== hw/rtl/tli_pkg.sv =====
// Shared types, codes and widths of the table linear interpolator.
`timescale 1ns / 1ps

package tli_pkg;

    // Widths fixed by the request fields.
    localparam int VAL_W     = 32;              // Q16.16 abscissa and ordinate
    localparam int IDX_W     = 9;               // entry_index field
    localparam int CNT_W     = 10;              // table_count register
    localparam int PROD_W    = 2 * VAL_W;       // product of two magnitudes
    localparam int TDATA_W   = 80;              // index, x, y padded to bytes
    localparam int TABLE_DEPTH_DEF = 512;

    // Request kinds carried on tuser.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Status of the shared divider.
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ===== hw/rtl/tli_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module tli_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/tli_div.sv =====
// Restoring unsigned divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module tli_div #(
    parameter int DW = tli_pkg::PROD_W,
    parameter int VW = tli_pkg::VAL_W,
    localparam int CW = $clog2(DW) + 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DW-1:0]        dividend,
    input  logic [VW-1:0]        divisor,
    output logic [DW-1:0]        quotient,
    output tli_pkg::div_status_t status
);

    logic [DW-1:0] quo_reg;
    logic [VW-1:0] rem_reg;
    logic [VW-1:0] den_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [VW:0]   shifted;
    logic [VW:0]   diff;
    logic          fits;

    // The remainder stays below the divisor, so the shifted value needs one bit more.
    assign shifted = {rem_reg, quo_reg[DW-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign fits    = (shifted >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            // Done pulses for one cycle after the last quotient bit is shifted in.
            done_reg <= busy_reg && !start && (cnt_reg == CW'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DW-2:0], fits};
            rem_reg <= fits ? diff[VW-1:0] : shifted[VW-1:0];
        end
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ===== hw/rtl/table_linear_interpolator_core.sv =====
// Top level of the piecewise linear table interpolator.
`timescale 1ns / 1ps

// Piecewise linear interpolation over a table of ascending Q16.16 points.
// A request with tuser = 0 loads one abscissa/ordinate pair into the slot given
// by entry_index and produces no result; loads to slots beyond the table depth
// are dropped. A request with tuser = 1 is a query: the block finds the two
// neighbours of the query abscissa among the first table_count entries and
// returns y1 + (y2 - y1) * (x - x1) / (x2 - x1), truncated toward zero and
// saturated to Q16.16. Queries outside the table extrapolate from the two end
// points; when both neighbours share an abscissa the lower ordinate comes back.
// All pairs sit in one RAM with one read port, so a query walks it entry by
// entry: two end-point reads, an upward and a downward scan, two neighbour
// reads, one 32x32 multiply and a 64-step shift-subtract divide. A query's
// result is registered at the output, and the next request can be taken in the
// same cycle as it appears. The scans read one entry per cycle; the divide holds
// the sequencer until the divider reports done. A load is written as it is taken.
// Requests are taken only between queries, which keeps scan reads clear of
// table writes, while a finished result may still be waiting on the master side.
// table_count is written through cfg_wr_en / cfg_wr_data; the user must write it
// only while no query is running, which the block itself does not enforce.
// Values below 2 act as 2 and values above the table depth act as the depth.

module table_linear_interpolator_core #(
    parameter int TABLE_DEPTH = tli_pkg::TABLE_DEPTH_DEF,
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int NW = (AW + 1 > tli_pkg::CNT_W) ? AW + 1 : tli_pkg::CNT_W
) (
    input  logic                         clk,
    input  logic                         rst_n,

    // Request stream.
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // s_tdata, lowest bit up: entry_index[8:0], x_value[40:9], y_value[72:41], zeros
    input  logic [tli_pkg::TDATA_W-1:0]  s_tdata,
    // s_tuser: op[0]
    input  logic [0:0]                   s_tuser,

    // Result stream.
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // m_tdata, lowest bit up: result_value[31:0]
    output logic [tli_pkg::VAL_W-1:0]    m_tdata,

    // Configuration of table_count.
    input  logic                         cfg_wr_en,
    input  logic [tli_pkg::CNT_W-1:0]    cfg_wr_data
);

    localparam int VW = tli_pkg::VAL_W;
    localparam int PW = tli_pkg::PROD_W;
    localparam int IW = tli_pkg::IDX_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIRST,
        S_LAST,
        S_UP,
        S_DN,
        S_GET_LO,
        S_GET_HI,
        S_MUL,
        S_DIV_GO,
        S_DIV,
        S_SUM,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic          m_tvalid_reg;
    logic [VW-1:0] m_tdata_reg;
    logic [tli_pkg::CNT_W-1:0] table_count_reg;

    // Datapath registers.
    logic signed [VW-1:0] x_q_reg;
    logic signed [VW-1:0] x1_reg;
    logic signed [VW-1:0] y1_reg;
    logic [AW-1:0]        lo_reg;
    logic [AW-1:0]        hi_reg;
    logic [VW-1:0]        mag_dy_reg;
    logic [VW-1:0]        mag_dq_reg;
    logic [VW-1:0]        mag_dx_reg;
    logic                 neg_reg;
    logic                 eq_reg;
    logic [PW-1:0]        prod_reg;
    logic signed [VW-1:0] result_reg;

    // Request fields.
    logic                 s_accept;
    logic                 in_op;
    logic [IW-1:0]        in_idx;
    logic signed [VW-1:0] in_x;
    logic signed [VW-1:0] in_y;

    assign in_idx = s_tdata[IW-1:0];
    assign in_x   = $signed(s_tdata[IW+VW-1:IW]);
    assign in_y   = $signed(s_tdata[IW+2*VW-1:IW+VW]);
    assign in_op  = s_tuser[0];

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // Active entry count, clamped to the legal range.
    logic [NW-1:0] n_ext;
    logic [NW-1:0] n_act;
    logic [AW-1:0] last_idx;

    assign n_ext = NW'(table_count_reg);

    always_comb
    begin
        if (n_ext < NW'(2))
        begin
            n_act = NW'(2);
        end
        else if (n_ext > NW'(TABLE_DEPTH))
        begin
            n_act = NW'(TABLE_DEPTH);
        end
        else
        begin
            n_act = n_ext;
        end
    end

    assign last_idx = AW'(n_act - NW'(1));

    // Table RAM: ordinate in the upper half, abscissa in the lower half.
    logic                 ram_we;
    logic [2*VW-1:0]      ram_rdata;
    logic signed [VW-1:0] rx;
    logic signed [VW-1:0] ry;

    assign ram_we = s_accept && (in_op == tli_pkg::OP_LOAD)
                    && (32'(in_idx) < TABLE_DEPTH);

    tli_ram #(
        .WIDTH (2 * VW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(in_idx)),
        .wdata ({in_y, in_x}),
        .raddr (ptr_next),
        .rdata (ram_rdata)
    );

    // The read address follows ptr_next, so ram_rdata always holds entry ptr_reg.
    assign rx = $signed(ram_rdata[VW-1:0]);
    assign ry = $signed(ram_rdata[2*VW-1:VW]);

    // Divider.
    logic                 div_start;
    logic [PW-1:0]        quotient;
    tli_pkg::div_status_t div_st;

    assign div_start = (state_reg == S_DIV_GO);

    tli_div #(
        .DW (PW),
        .VW (VW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (mag_dx_reg),
        .quotient (quotient),
        .status   (div_st)
    );

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        ptr_next   = ptr_reg;
        case (state_reg)
            S_IDLE:
            begin
                ptr_next = '0;
                if (s_accept && (in_op == tli_pkg::OP_QUERY))
                begin
                    state_next = S_FIRST;
                end
            end
            S_FIRST:
            begin
                // Below the first point: extrapolate from entries 0 and 1.
                if (x_q_reg < rx)
                begin
                    ptr_next   = '0;
                    state_next = S_GET_LO;
                end
                else
                begin
                    ptr_next   = last_idx;
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                // Above the last point: extrapolate from the two top entries.
                if (x_q_reg > rx)
                begin
                    ptr_next   = last_idx - AW'(1);
                    state_next = S_GET_LO;
                end
                else
                begin
                    // Entry 0 is known not to exceed x, so the upward scan starts at 1.
                    ptr_next   = AW'(1);
                    state_next = S_UP;
                end
            end
            S_UP:
            begin
                if ((x_q_reg >= rx) && (ptr_reg != last_idx))
                begin
                    ptr_next = ptr_reg + AW'(1);
                end
                else
                begin
                    ptr_next   = last_idx;
                    state_next = S_DN;
                end
            end
            S_DN:
            begin
                if ((x_q_reg <= rx) && (ptr_reg != '0))
                begin
                    ptr_next = ptr_reg - AW'(1);
                end
                else
                begin
                    ptr_next   = lo_reg;
                    state_next = S_GET_LO;
                end
            end
            S_GET_LO:
            begin
                ptr_next   = hi_reg;
                state_next = S_GET_HI;
            end
            S_GET_HI:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = eq_reg ? S_OUT : S_DIV_GO;
            end
            S_DIV_GO:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_st.done)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            ptr_reg         <= '0;
            m_tvalid_reg    <= 1'b0;
            m_tdata_reg     <= '0;
            table_count_reg <= tli_pkg::CNT_W'(2);
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            if (cfg_wr_en)
            begin
                table_count_reg <= cfg_wr_data;
            end
            // A new result replaces the one taken in the same cycle.
            if ((state_reg == S_OUT) && (!m_tvalid_reg || m_tready))
            begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= result_reg;
            end
            else if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Differences of the chosen neighbours, extended to 33 bits.
    logic signed [VW:0] dy;
    logic signed [VW:0] dq;
    logic signed [VW:0] dx;
    logic [VW:0]        dy_abs;
    logic [VW:0]        dq_abs;
    logic [VW:0]        dx_abs;

    assign dy = {ry[VW-1], ry} - {y1_reg[VW-1], y1_reg};
    assign dq = {x_q_reg[VW-1], x_q_reg} - {x1_reg[VW-1], x1_reg};
    assign dx = {rx[VW-1], rx} - {x1_reg[VW-1], x1_reg};
    assign dy_abs = dy[VW] ? (~dy + 1'b1) : dy;
    assign dq_abs = dq[VW] ? (~dq + 1'b1) : dq;
    assign dx_abs = dx[VW] ? (~dx + 1'b1) : dx;

    logic [PW-1:0] prod_c;
    assign prod_c = mag_dy_reg * mag_dq_reg;

    // Final sum; a quotient of 2^34 or more saturates whatever y1 is.
    logic                   q_big;
    logic signed [VW+3:0]   sum_c;
    logic signed [VW+3:0]   y1_ext;
    logic signed [VW+3:0]   q_ext;
    logic signed [VW-1:0]   sat_c;

    assign q_big  = |quotient[PW-1:VW+2];
    assign y1_ext = {{4{y1_reg[VW-1]}}, y1_reg};
    assign q_ext  = {2'b00, quotient[VW+1:0]};
    assign sum_c  = neg_reg ? (y1_ext - q_ext) : (y1_ext + q_ext);

    always_comb
    begin
        if (q_big)
        begin
            sat_c = neg_reg ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
        end
        else if (sum_c[VW+3:VW-1] == '0 || sum_c[VW+3:VW-1] == '1)
        begin
            sat_c = sum_c[VW-1:0];
        end
        else
        begin
            sat_c = sum_c[VW+3] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                x_q_reg <= in_x;
            end
            S_FIRST:
            begin
                lo_reg <= '0;
                hi_reg <= AW'(1);
            end
            S_LAST:
            begin
                lo_reg <= last_idx - AW'(1);
                hi_reg <= last_idx;
            end
            S_UP:
            begin
                // The scan ends at the first entry above x, or runs off the top.
                if (x_q_reg >= rx)
                begin
                    lo_reg <= last_idx;
                end
                else
                begin
                    lo_reg <= ptr_reg - AW'(1);
                end
            end
            S_DN:
            begin
                // Running off the bottom selects entry 0 as the upper neighbour.
                if (x_q_reg <= rx)
                begin
                    hi_reg <= '0;
                end
                else
                begin
                    hi_reg <= ptr_reg + AW'(1);
                end
            end
            S_GET_LO:
            begin
                x1_reg <= rx;
                y1_reg <= ry;
            end
            S_GET_HI:
            begin
                mag_dy_reg <= dy_abs[VW-1:0];
                mag_dq_reg <= dq_abs[VW-1:0];
                mag_dx_reg <= dx_abs[VW-1:0];
                neg_reg    <= dy[VW] != dq[VW];
                eq_reg     <= (rx == x1_reg);
            end
            S_MUL:
            begin
                prod_reg   <= prod_c;
                result_reg <= y1_reg;
            end
            S_SUM:
            begin
                result_reg <= sat_c;
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The divider never runs while requests are being taken.
    a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !div_st.busy)
        else $error("divider busy while requests are accepted");

    // A result appears only from the output step of a query.
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == S_OUT))
        else $error("result raised outside the output step");

    // The divider finishes only while the sequencer waits for it.
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_st.done |-> (state_reg == S_DIV))
        else $error("divider finished outside the divide step");

    // Scans stay inside the active part of the table.
    a_scan_rng: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UP || state_reg == S_DN) |-> (ptr_reg <= last_idx))
        else $error("scan pointer beyond the active entries");

endmodule

// ===== tb/table_linear_interpolator_core_test.sv =====
// Self-checking testbench for the table linear interpolator core.
`timescale 1ns / 1ps

module table_linear_interpolator_core_test;

    localparam int VAL_W          = tli_pkg::VAL_W;
    localparam int IDX_W          = tli_pkg::IDX_W;
    localparam int CNT_W          = tli_pkg::CNT_W;
    localparam int TDATA_W        = tli_pkg::TDATA_W;
    localparam int DEPTH          = tli_pkg::TABLE_DEPTH_DEF;
    localparam int ITEM_GOAL      = 1000;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD      = 300;
    localparam longint Q_MAX      = 64'sh0000_0000_7FFF_FFFF;
    localparam longint Q_MIN      = -Q_MAX - 1;

    // One request as the generator queues it for the driver.
    typedef struct {
        logic                    op;
        logic [IDX_W-1:0]        slot;
        logic signed [VAL_W-1:0] ax;
        logic signed [VAL_W-1:0] ay;
    } tli_request_t;

    // Ways the result side takes results when it is not in a long hold.
    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_RARE,
        READY_PERIODIC
    } ready_style_t;

    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   s_tvalid    = 1'b0;
    logic                   s_tready;
    logic [TDATA_W-1:0]     s_tdata     = '0;
    logic [0:0]             s_tuser     = '0;
    logic                   m_tvalid;
    logic                   m_tready    = 1'b0;
    logic [VAL_W-1:0]       m_tdata;
    logic                   cfg_wr_en   = 1'b0;
    logic [CNT_W-1:0]       cfg_wr_data = '0;

    // Requests waiting for the driver, and interpolated values waiting for the block.
    tli_request_t           request_queue[$];
    logic [VAL_W-1:0]       expected_results[$];

    // Predictor state: the table as the block holds it and the size register.
    logic signed [VAL_W-1:0] abscissa_tbl [DEPTH];
    logic signed [VAL_W-1:0] ordinate_tbl [DEPTH];
    logic [CNT_W-1:0]        table_size_reg = 10'd2;

    // Generator view of the table, used to aim queries at points and spans.
    logic signed [VAL_W-1:0] gen_x [DEPTH];
    logic signed [VAL_W-1:0] gen_y [DEPTH];
    bit                      slot_loaded [DEPTH];
    int                      loaded_slots = 0;
    int                      items_queued = 0;

    int err_count       = 0;
    int results_checked = 0;
    int loads_applied   = 0;
    int queries_taken   = 0;
    int extrapolated    = 0;
    int saturated       = 0;
    int flat_spans      = 0;
    int settings_tried  = 0;
    int quiet_cycles    = 0;

    // Driver and receiver bookkeeping.
    int           burst_left   = 0;
    int           gap_left     = 0;
    int           hold_requests = 0;
    int           holds_done   = 0;
    int           hold_left    = 0;
    int           style_left   = 0;
    int           ready_tick   = 0;
    ready_style_t ready_style  = READY_ALWAYS;
    tli_request_t next_req;

    table_linear_interpolator_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The size register acts as 2 below 2 and as the table depth above it.
    function automatic int active_entries_of(logic [CNT_W-1:0] setting);
        if (setting < 2)
        begin
            return 2;
        end
        if (setting > DEPTH)
        begin
            return DEPTH;
        end
        return int'(setting);
    endfunction

    // Expected Q16.16 value of a query: pick the two neighbours the same way the
    // block's scans do, then y1 + dy * dx / span with truncation and saturation.
    function automatic logic [VAL_W-1:0] interpolate_q16(logic signed [VAL_W-1:0] query_x);
        int          n;
        int          lo;
        int          hi;
        int          up;
        int          dn;
        longint      qx;
        longint      x1;
        longint      x2;
        longint      y1;
        longint      dy;
        longint      dx;
        longint      total;
        logic [63:0] mag_dy;
        logic [63:0] mag_dx;
        logic [63:0] quo;
        bit          neg;
        n  = active_entries_of(table_size_reg);
        qx = query_x;
        if (qx < longint'(abscissa_tbl[0]))
        begin
            lo = 0;
            hi = 1;
            extrapolated++;
        end
        else if (qx > longint'(abscissa_tbl[n - 1]))
        begin
            lo = n - 2;
            hi = n - 1;
            extrapolated++;
        end
        else
        begin
            // The upward scan finds the last point not above x, the downward
            // scan the first point not below it; on an exact hit both meet.
            up = 0;
            while (up < n && qx >= longint'(abscissa_tbl[up]))
            begin
                up++;
            end
            lo = up - 1;
            dn = n - 1;
            while (dn >= 0 && qx <= longint'(abscissa_tbl[dn]))
            begin
                dn--;
            end
            hi = dn + 1;
        end
        x1 = abscissa_tbl[lo];
        x2 = abscissa_tbl[hi];
        y1 = ordinate_tbl[lo];
        if (x1 == x2)
        begin
            flat_spans++;
            return ordinate_tbl[lo];
        end
        dy     = longint'(ordinate_tbl[hi]) - y1;
        dx     = qx - x1;
        mag_dy = (dy < 0) ? -dy : dy;
        mag_dx = (dx < 0) ? -dx : dx;
        quo    = (mag_dy * mag_dx) / ((x2 > x1) ? x2 - x1 : x1 - x2);
        neg    = (dy < 0) != (dx < 0);
        if (quo >= (64'd1 << 34))
        begin
            saturated++;
            return neg ? VAL_W'(Q_MIN) : VAL_W'(Q_MAX);
        end
        total = neg ? y1 - longint'(quo) : y1 + longint'(quo);
        if (total > Q_MAX || total < Q_MIN)
        begin
            saturated++;
            total = (total > Q_MAX) ? Q_MAX : Q_MIN;
        end
        return VAL_W'(total);
    endfunction

    function automatic longint pick_between(longint lo, longint hi);
        longint unsigned raw;
        raw = {$urandom, $urandom};
        return lo + longint'(raw % (hi - lo + 1));
    endfunction

    task automatic queue_load(int slot, logic signed [VAL_W-1:0] ax,
                              logic signed [VAL_W-1:0] ay);
        tli_request_t r;
        r.op   = tli_pkg::OP_LOAD;
        r.slot = IDX_W'(slot);
        r.ax   = ax;
        r.ay   = ay;
        request_queue.push_back(r);
        gen_x[slot] = ax;
        gen_y[slot] = ay;
        if (!slot_loaded[slot])
        begin
            slot_loaded[slot] = 1'b1;
            loaded_slots++;
        end
        items_queued++;
    endtask

    task automatic queue_query(logic signed [VAL_W-1:0] qx);
        tli_request_t r;
        r.op   = tli_pkg::OP_QUERY;
        r.slot = IDX_W'($urandom);
        r.ax   = qx;
        r.ay   = $urandom;
        request_queue.push_back(r);
        items_queued++;
    endtask

    // Loads slots 0..n-1 with a fresh table: mostly ascending at one of three
    // scales, sometimes with repeated abscissae, now and then scattered.
    task automatic build_table(int n);
        logic signed [VAL_W-1:0] xs [DEPTH];
        logic signed [VAL_W-1:0] ys;
        longint stride_cap;
        longint ax;
        int     dup_odds;
        int     slot;
        bit     scatter;
        bit     small_y;
        bit     descending;
        case ($urandom_range(0, 2))
            0:       stride_cap = 16;
            1:       stride_cap = 64'd1 << 18;
            default: stride_cap = 64'hFFFF_FFFF / n;
        endcase
        dup_odds   = ($urandom_range(0, 3) == 0) ? 4 : 0;
        scatter    = ($urandom_range(0, 7) == 0);
        small_y    = 1'($urandom_range(0, 1));
        descending = 1'($urandom_range(0, 1));
        ax = pick_between(Q_MIN, Q_MAX - stride_cap * (n - 1));
        for (int i = 0; i < n; i++)
        begin
            xs[i] = scatter ? VAL_W'($urandom) : VAL_W'(ax);
            if (dup_odds == 0 || $urandom_range(1, dup_odds) != 1)
            begin
                ax += pick_between(1, stride_cap);
            end
        end
        for (int k = 0; k < n; k++)
        begin
            slot = descending ? n - 1 - k : k;
            ys   = small_y ? $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000
                           : $signed($urandom);
            queue_load(slot, xs[slot], ys);
        end
    endtask

    // Queries aimed at table points, inside the table, beyond either end and
    // anywhere, with an occasional load mixed in that rewrites the table.
    task automatic add_queries(int n, int count);
        longint lo_x;
        longint hi_x;
        longint qx;
        int     slot;
        repeat (count)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                slot = (n < DEPTH && $urandom_range(0, 1)) ? $urandom_range(n, DEPTH - 1)
                                                           : $urandom_range(0, n - 1);
                queue_load(slot, $urandom, $urandom);
            end
            lo_x = gen_x[0];
            hi_x = gen_x[n - 1];
            case ($urandom_range(0, 9))
                0, 1, 2: qx = gen_x[$urandom_range(0, n - 1)];
                3, 4, 5: qx = (lo_x < hi_x) ? pick_between(lo_x, hi_x) : pick_between(hi_x, lo_x);
                6:       qx = (lo_x > Q_MIN) ? pick_between(Q_MIN, lo_x - 1) : Q_MIN;
                7:       qx = (hi_x < Q_MAX) ? pick_between(hi_x + 1, Q_MAX) : Q_MAX;
                default: qx = $signed($urandom);
            endcase
            queue_query(VAL_W'(qx));
        end
    endtask

    // Waits until every queued request is taken and every result is back, then
    // gives trailing loads the longest query latency to finish.
    task automatic wait_until_drained(int n);
        while (request_queue.size() != 0 || s_tvalid || expected_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (2 * n + 80) @(negedge clk);
    endtask

    // Request driver: bursts of random length with random gaps. Valid stays up
    // until the block takes the request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (gap_left != 0 || request_queue.size() == 0)
            begin
                s_tvalid <= 1'b0;
                if (gap_left != 0)
                begin
                    gap_left--;
                end
            end
            else
            begin
                next_req = request_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {{(TDATA_W - IDX_W - 2 * VAL_W){1'b0}},
                             next_req.ay, next_req.ax, next_req.slot};
                s_tuser  <= next_req.op;
                if (burst_left > 0)
                begin
                    burst_left--;
                end
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
        end
    end

    // Result receiver: a changing ready style, plus long holds on demand so the
    // block backs up and stalls its request side.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            ready_tick++;
            if (holds_done != hold_requests && hold_left == 0)
            begin
                hold_left = LONG_HOLD;
                holds_done++;
            end
            if (style_left == 0)
            begin
                ready_style = ready_style_t'($urandom_range(0, 3));
                style_left  = $urandom_range(32, 256);
            end
            else
            begin
                style_left--;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                case (ready_style)
                    READY_ALWAYS: m_tready <= 1'b1;
                    READY_COIN:   m_tready <= 1'($urandom_range(0, 1));
                    READY_RARE:   m_tready <= ($urandom_range(0, 6) == 0);
                    default:      m_tready <= (ready_tick % 3 == 0);
                endcase
            end
        end
    end

    // Monitor: tracks register writes, checks results in order and predicts the
    // result of every query request the block takes.
    always @(posedge clk)
    begin : monitor
        logic [VAL_W-1:0] want;
        if (rst_n)
        begin
            if (cfg_wr_en)
            begin
                table_size_reg = cfg_wr_data;
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    if (err_count < 10)
                    begin
                        $display("error: result %h came with no query outstanding", m_tdata);
                    end
                    err_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    results_checked++;
                    if (m_tdata !== want)
                    begin
                        if (err_count < 10)
                        begin
                            $display("error: result %0d result_value expected %h, got %h",
                                     results_checked, want, m_tdata);
                        end
                        err_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser[0] == tli_pkg::OP_QUERY)
                begin
                    expected_results.push_back(interpolate_q16(s_tdata[40:9]));
                    queries_taken++;
                end
                else
                begin
                    abscissa_tbl[s_tdata[8:0]] = s_tdata[40:9];
                    ordinate_tbl[s_tdata[8:0]] = s_tdata[72:41];
                    loads_applied++;
                end
            end
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
        begin
            quiet_cycles = 0;
        end
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("timeout: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
        else
        begin
            quiet_cycles++;
        end
    end

    // Stimulus: a directed table at the reset size, then phases that each set
    // the size register while idle, load or reuse a table, and query it.
    initial
    begin
        logic [CNT_W-1:0] size_setting;
        int               phase;
        int               n;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // End points at the extremes of Q16.16, and queries that hit them exactly.
        queue_load(0, 32'sh8000_0000, 32'sh7FFF_FFFF);
        queue_load(1, 32'sh7FFF_FFFF, 32'sh8000_0000);
        queue_query(32'sh8000_0000);
        queue_query(32'sh7FFF_FFFF);
        queue_query(32'sh0000_0000);
        // A steep unit span: far extrapolation both ways saturates.
        queue_load(0, 32'sh0000_0000, 32'sh0000_0000);
        queue_load(1, 32'sh0001_0000, 32'sh7FFF_FFFF);
        queue_query(32'sh7FFF_FFFF);
        queue_query(32'sh8000_0000);
        queue_query(32'sh0000_8000);
        // Both end points on the same abscissa: no division, lower ordinate back.
        queue_load(1, 32'sh0000_0000, 32'sh0000_0005);
        queue_query(32'sh0000_0000);
        queue_query(32'shFFFF_FFFF);
        queue_query(32'sh0000_0007);
        // A table that runs downward, searched by the same rules.
        queue_load(0, 32'sh0000_0064, 32'sh0000_03E8);
        queue_load(1, 32'shFFFF_FF9C, 32'shFFFF_FC18);
        queue_query(32'sh0000_0000);
        queue_query(32'sh0000_0096);
        // The top slot, and a negative slope where the quotient truncates toward zero.
        queue_load(DEPTH - 1, 32'sh7FFF_FFFF, 32'shFFFF_FFFF);
        queue_load(0, 32'sh0000_0000, 32'sh0000_0000);
        queue_load(1, 32'sh0000_0003, 32'shFFFF_FFF6);
        queue_query(32'sh0000_0001);
        queue_query(32'sh0000_0002);

        n     = 2;
        phase = 0;
        while (items_queued < ITEM_GOAL)
        begin
            wait_until_drained(n);
            case (phase)
                0:       size_setting = 10'd5;
                1:       size_setting = 10'd0;
                2:       size_setting = 10'd512;
                3:       size_setting = 10'd1023;
                4:       size_setting = 10'd1;
                5:       size_setting = 10'd513;
                6:       size_setting = 10'd2;
                default: size_setting = ($urandom_range(0, 7) == 0)
                                        ? CNT_W'($urandom_range(9, 64))
                                        : CNT_W'($urandom_range(2, 8));
            endcase
            @(posedge clk);
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= size_setting;
            @(posedge clk);
            cfg_wr_en   <= 1'b0;
            @(negedge clk);
            n = active_entries_of(size_setting);
            settings_tried++;
            // A full-depth table is loaded once and then reused as it stands.
            if (n < DEPTH || loaded_slots < DEPTH)
            begin
                build_table(n);
            end
            if (phase % 9 == 4)
            begin
                hold_requests++;
            end
            add_queries(n, (n == DEPTH) ? 6 : $urandom_range(8, 30));
            phase++;
        end
        wait_until_drained(n);

        $display("Covered %0d loads and %0d queries over %0d size settings (0 to 1023).",
                 loads_applied, queries_taken, settings_tried);
        $display("%0d results checked: %0d extrapolated, %0d saturated, %0d on a flat span.",
                 results_checked, extrapolated, saturated, flat_spans);
        if (err_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("%0d failures", err_count);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
